@@ design/pbc_pkg.sv @@
package pbc_pkg;

    // Point format and plane accumulator sizing
    localparam int COORD_W          = 24;
    localparam int MAX_PLANE_POINTS = 65536;
    localparam int COUNT_W          = $clog2(MAX_PLANE_POINTS + 1);
    localparam int SUM_W            = COORD_W + COUNT_W;
    localparam int WIDE_W           = SUM_W + 1;
    localparam int DIV_CNT_W        = $clog2(SUM_W + 1);

    // Front queue between acceptance and execution
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_Z = 2'd2;

    // Request codes
    localparam logic REQ_PLANE = 1'b0;
    localparam logic REQ_SCENE = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // One queued word
    typedef struct packed {
        logic   req_type;
        logic   first_point;
        logic   finalize;
        logic   on_support;
        coord_t x;
        coord_t y;
        coord_t z;
    } item_t;

    // Divider status toward the back end
    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
        logic             rem_nz;
    } div_status_t;

    // Sign-extend a coordinate to the wide arithmetic width
    function automatic wide_t widen(input coord_t v);
        return {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    // Clamp a wide value to the signed coordinate range
    function automatic coord_t sat_coord(input wide_t v);
        coord_t r;
        if (v > widen(COORD_MAX))
            r = COORD_MAX;
        else if (v < widen(COORD_MIN))
            r = COORD_MIN;
        else
            r = v[COORD_W-1:0];
        return r;
    endfunction

endpackage

@@ design/plane_bbox_point_crop_core.sv @@
// Crop-box filter above a support plane. Load the plane points first (req_type 0,
// first_point on the first, last_point on the last), then send scene points
// (req_type 1); each scene point gives exactly one result, strobed by
// result_valid for one cycle once it has passed the queue and the result
// register. The block has no output backpressure: results must be taken when
// shown. Words are accepted while busy is low into a four-word queue. Plane and
// scene points execute at one per cycle while no finalize is in flight; a plane
// point with last_point set occupies the execution side for the take step, a
// divider start step, the divide state and a finalize step, dominated by the 41-step
// bit-serial division of the height sum by the point count, during which the
// queue fills and busy rises. Write configuration only while the block is idle.
module plane_bbox_point_crop_core
    import pbc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 req_type,
    input  logic                 first_point,
    input  logic                 last_point,
    input  coord_t               coord_x,
    input  coord_t               coord_y,
    input  coord_t               coord_z,
    input  logic                 on_support,
    output logic                 result_valid,
    output logic                 keep,
    output coord_t               out_x,
    output coord_t               out_y,
    output coord_t               out_z,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  coord_t               cfg_data
);

    coord_t ofs_x_reg, ofs_y_reg, ofs_z_reg;
    item_t  in_item;
    item_t  head;
    logic   not_empty;
    logic   pop;

    // Latch configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ofs_x_reg <= '0;
            ofs_y_reg <= '0;
            ofs_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EDGE_X:   ofs_x_reg <= cfg_data;
                CFG_EDGE_Y:   ofs_y_reg <= cfg_data;
                CFG_HEIGHT_Z: ofs_z_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Classify the incoming word
    always_comb
    begin
        in_item.req_type    = req_type;
        in_item.first_point = first_point;
        in_item.finalize    = (req_type == REQ_PLANE) && last_point;
        in_item.on_support  = on_support;
        in_item.x           = coord_x;
        in_item.y           = coord_y;
        in_item.z           = coord_z;
    end

    pbc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .in_item   (in_item),
        .busy      (busy),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty)
    );

    pbc_exec u_exec (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .not_empty    (not_empty),
        .pop          (pop),
        .ofs_x        (ofs_x_reg),
        .ofs_y        (ofs_y_reg),
        .ofs_z        (ofs_z_reg),
        .result_valid (result_valid),
        .keep         (keep),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z)
    );

endmodule

@@ design/pbc_queue.sv @@
module pbc_queue
    import pbc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  item_t in_item,
    output logic  busy,
    input  logic  pop,
    output item_t head,
    output logic  not_empty
);

    item_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push;

    // Accept a word whenever there is room
    assign busy      = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign push      = start && !busy;
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

@@ design/pbc_divider.sv @@
module pbc_divider
    import pbc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               div_start,
    input  logic [SUM_W-1:0]   dividend,
    input  logic [COUNT_W-1:0] divisor,
    output div_status_t        status
);

    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [COUNT_W-1:0]   dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 active_reg, active_next;
    logic                 done_reg, done_next;
    logic [COUNT_W:0]     trial;
    logic [COUNT_W:0]     diff;
    logic                 fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (div_start)
        begin
            quo_next    = dividend;
            rem_next    = '0;
            cnt_next    = DIV_CNT_W'(SUM_W);
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            quo_next = {quo_reg[SUM_W-2:0], fits};
            rem_next = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (div_start)
            dvs_reg <= divisor;
    end

    assign status.done     = done_reg;
    assign status.quotient = quo_reg;
    assign status.rem_nz   = (rem_reg != '0);

endmodule

@@ design/pbc_exec.sv @@
module pbc_exec
    import pbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       head,
    input  logic        not_empty,
    output logic        pop,
    input  coord_t      ofs_x,
    input  coord_t      ofs_y,
    input  coord_t      ofs_z,
    output logic        result_valid,
    output logic        keep,
    output coord_t      out_x,
    output coord_t      out_y,
    output coord_t      out_z
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DSTART = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_FINAL  = 4'b1000
    } state_t;

    state_t                    state_reg, state_next;
    coord_t                    x_low_reg, x_low_next;
    coord_t                    x_high_reg, x_high_next;
    coord_t                    y_low_reg, y_low_next;
    coord_t                    y_high_reg, y_high_next;
    logic signed [SUM_W-1:0]   z_sum_reg, z_sum_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    coord_t                    thresh_reg, thresh_next;
    logic                      bvalid_reg, bvalid_next;
    logic                      res_valid_reg, res_valid_next;
    logic                      keep_reg, keep_next;
    coord_t                    ox_reg, oy_reg, oz_reg;

    coord_t                    base_xl, base_xh, base_yl, base_yh;
    logic signed [SUM_W-1:0]   base_sum;
    logic [COUNT_W-1:0]        base_cnt;
    logic                      sum_neg;
    logic [SUM_W-1:0]          sum_mag;
    logic                      div_start;
    div_status_t               div_stat;
    wide_t                     q_sel;
    wide_t                     thr_wide;
    logic                      q_cin;
    logic                      plane_pop;
    logic                      scene_pop;

    // Take a word only while no finalize is in flight
    assign pop       = (state_reg == ST_IDLE) && not_empty;
    assign plane_pop = pop && (head.req_type == REQ_PLANE);
    assign scene_pop = pop && (head.req_type == REQ_SCENE);

    // Accumulator starting point: fresh on the first plane word
    always_comb
    begin
        base_xl  = head.first_point ? COORD_MAX : x_low_reg;
        base_xh  = head.first_point ? COORD_MIN : x_high_reg;
        base_yl  = head.first_point ? COORD_MAX : y_low_reg;
        base_yh  = head.first_point ? COORD_MIN : y_high_reg;
        base_sum = head.first_point ? '0 : z_sum_reg;
        base_cnt = head.first_point ? '0 : count_reg;
    end

    // Magnitude of the height sum for the unsigned divider
    assign sum_neg   = z_sum_reg[SUM_W-1];
    assign sum_mag   = sum_neg ? (~z_sum_reg + 1'b1) : z_sum_reg;
    assign div_start = (state_reg == ST_DSTART);

    pbc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .div_start (div_start),
        .dividend  (sum_mag),
        .divisor   (count_reg),
        .status    (div_stat)
    );

    // Floor of the signed mean plus offset in one add: -q-1 is ~q
    assign q_sel    = sum_neg ? ~{1'b0, div_stat.quotient} : {1'b0, div_stat.quotient};
    assign q_cin    = sum_neg && !div_stat.rem_nz;
    assign thr_wide = q_sel + widen(ofs_z) + WIDE_W'(q_cin);

    always_comb
    begin
        state_next     = state_reg;
        x_low_next     = x_low_reg;
        x_high_next    = x_high_reg;
        y_low_next     = y_low_reg;
        y_high_next    = y_high_reg;
        z_sum_next     = z_sum_reg;
        count_next     = count_reg;
        thresh_next    = thresh_reg;
        bvalid_next    = bvalid_reg;
        res_valid_next = 1'b0;
        keep_next      = keep_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (plane_pop)
                begin
                    // Track bounds and sum heights
                    bvalid_next = 1'b0;
                    x_low_next  = (head.x < base_xl) ? head.x : base_xl;
                    x_high_next = (head.x > base_xh) ? head.x : base_xh;
                    y_low_next  = (head.y < base_yl) ? head.y : base_yl;
                    y_high_next = (head.y > base_yh) ? head.y : base_yh;
                    z_sum_next  = base_sum;
                    count_next  = base_cnt;
                    if (base_cnt < COUNT_W'(MAX_PLANE_POINTS))
                    begin
                        z_sum_next = base_sum + SUM_W'(widen(head.z));
                        count_next = base_cnt + 1'b1;
                    end
                    if (head.finalize)
                        state_next = ST_DSTART;
                end
                else if (scene_pop)
                begin
                    // Crop test against the shrunk box and height
                    res_valid_next = 1'b1;
                    keep_next = bvalid_reg && !head.on_support &&
                                (head.x > x_low_reg) && (head.x < x_high_reg) &&
                                (head.y > y_low_reg) && (head.y < y_high_reg) &&
                                (head.z > thresh_reg);
                end
            end
            ST_DSTART:
                state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                // Shrink the box and set the height threshold
                x_low_next  = sat_coord(widen(x_low_reg) + widen(ofs_x));
                x_high_next = sat_coord(widen(x_high_reg) - widen(ofs_x));
                y_low_next  = sat_coord(widen(y_low_reg) + widen(ofs_y));
                y_high_next = sat_coord(widen(y_high_reg) - widen(ofs_y));
                thresh_next = sat_coord(thr_wide);
                bvalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            x_low_reg     <= COORD_MAX;
            x_high_reg    <= COORD_MIN;
            y_low_reg     <= COORD_MAX;
            y_high_reg    <= COORD_MIN;
            z_sum_reg     <= '0;
            count_reg     <= '0;
            thresh_reg    <= '0;
            bvalid_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
            keep_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            x_low_reg     <= x_low_next;
            x_high_reg    <= x_high_next;
            y_low_reg     <= y_low_next;
            y_high_reg    <= y_high_next;
            z_sum_reg     <= z_sum_next;
            count_reg     <= count_next;
            thresh_reg    <= thresh_next;
            bvalid_reg    <= bvalid_next;
            res_valid_reg <= res_valid_next;
            keep_reg      <= keep_next;
        end
    end

    // Hold the echoed coordinates of the last scene word
    always_ff @(posedge clk)
    begin
        if (scene_pop)
        begin
            ox_reg <= head.x;
            oy_reg <= head.y;
            oz_reg <= head.z;
        end
    end

    assign result_valid = res_valid_reg;
    assign keep         = keep_reg;
    assign out_x        = ox_reg;
    assign out_y        = oy_reg;
    assign out_z        = oz_reg;

    a_result_from_scene: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> $past(scene_pop))
        else $error("result without a scene word");

    a_valid_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(bvalid_reg) |-> $past(state_reg == ST_FINAL))
        else $error("bounds valid set outside finalize");

    a_no_pop_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !pop)
        else $error("word taken during finalize");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

endmodule
